// ----- design/nprs_pkg.sv -----
// ----------------------------------------------------------------------------
// nprs_pkg
// Shared widths, command codes and record types of the nearest point search.
// ----------------------------------------------------------------------------
`default_nettype none

package nprs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SLOT_W      = 10;
  localparam int CMP_W       = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
  localparam int KEY_W       = 16;
  localparam int POS_W       = 24;
  localparam int REACH_W     = 23;
  localparam int SQ_W        = 2 * POS_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int LIM2_W      = 2 * REACH_W;
  localparam int CMD_W       = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CMP_W-1:0]  slot_ext_t;
  typedef logic [SUM_W-1:0]  sum_t;

  localparam addr_t LAST_ADDR = addr_t'(TABLE_DEPTH - 1);

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic                    written;
    logic                    active;
    logic                    enabled;
    logic [KEY_W-1:0]        key;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [REACH_W-1:0]      reach;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                    vld;
    logic                    qual;
    logic                    last;
    logic [KEY_W-1:0]        key;
    logic [REACH_W-1:0]      lim;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    sum_t                    sum;
  } scan_t;

  typedef struct packed {
    logic             vld;
    logic             found;
    logic [KEY_W-1:0] key;
  } res_t;

endpackage

`default_nettype wire

// ----- design/nprs_ram.sv -----
// ----------------------------------------------------------------------------
// nprs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/nprs_axis_cell.sv -----
// ----------------------------------------------------------------------------
// nprs_axis_cell
// One cell of the distance chain: holds one query coordinate, adds the squared
// difference of the leading entry coordinate and rotates the coordinates on.
// ----------------------------------------------------------------------------
`default_nettype none

module nprs_axis_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_load,
  input  wire logic signed [nprs_pkg::POS_W-1:0] q_pos,
  input  wire nprs_pkg::scan_t                   cell_in,
  output nprs_pkg::scan_t                        cell_out
);

  logic signed [nprs_pkg::POS_W-1:0] q_r;
  logic signed [nprs_pkg::POS_W:0]   diff;
  logic [nprs_pkg::POS_W-1:0]        mag_nxt;
  logic [nprs_pkg::POS_W-1:0]        mag_r;
  logic [nprs_pkg::SQ_W-1:0]         sq;
  nprs_pkg::scan_t                   s1_nxt;
  nprs_pkg::scan_t                   s1_r;
  nprs_pkg::scan_t                   s2_nxt;
  nprs_pkg::scan_t                   s2_r;
  logic                              s1_vld_r;
  logic                              s2_vld_r;

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_r <= q_pos;
    end
  end

  always_comb begin
    diff    = {cell_in.cx[nprs_pkg::POS_W-1], cell_in.cx} - {q_r[nprs_pkg::POS_W-1], q_r};
    mag_nxt = diff[nprs_pkg::POS_W] ? nprs_pkg::POS_W'(-diff) : nprs_pkg::POS_W'(diff);
    s1_nxt    = cell_in;
    s1_nxt.cx = cell_in.cy;
    s1_nxt.cy = cell_in.cz;
    s1_nxt.cz = cell_in.cx;
  end

  always_comb begin
    sq         = mag_r * mag_r;
    s2_nxt     = s1_r;
    s2_nxt.sum = s1_r.sum + nprs_pkg::SUM_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cell_in.vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    mag_r <= mag_nxt;
    s2_r  <= s2_nxt;
  end

  always_comb begin
    cell_out     = s2_r;
    cell_out.vld = s2_vld_r;
  end

endmodule

`default_nettype wire

// ----- design/nprs_best.sv -----
// ----------------------------------------------------------------------------
// nprs_best
// Limit check and running minimum at the end of the chain; emits one result
// when the last slot of a query has passed.
// ----------------------------------------------------------------------------
`default_nettype none

module nprs_best (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nprs_pkg::scan_t best_in,
  output nprs_pkg::res_t       res
);

  logic                        b_vld_r;
  logic                        qual_r;
  logic                        last_r;
  logic [nprs_pkg::KEY_W-1:0]  key_r;
  nprs_pkg::sum_t              d2_r;
  logic [nprs_pkg::LIM2_W-1:0] lim2_nxt;
  logic [nprs_pkg::LIM2_W-1:0] lim2_r;
  logic                        hit;
  logic                        better;
  logic                        found_nxt;
  logic                        found_r;
  nprs_pkg::sum_t              best_nxt;
  nprs_pkg::sum_t              best_r;
  logic [nprs_pkg::KEY_W-1:0]  bkey_nxt;
  logic [nprs_pkg::KEY_W-1:0]  bkey_r;
  logic                        res_vld_r;
  logic                        res_found_r;
  logic [nprs_pkg::KEY_W-1:0]  res_key_r;

  assign lim2_nxt = best_in.lim * best_in.lim;

  always_comb begin
    hit       = qual_r && (d2_r < nprs_pkg::SUM_W'(lim2_r));
    better    = hit && (!found_r || (d2_r < best_r));
    found_nxt = found_r || better;
    best_nxt  = better ? d2_r : best_r;
    bkey_nxt  = better ? key_r : bkey_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      found_r   <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      b_vld_r   <= best_in.vld;
      res_vld_r <= b_vld_r && last_r;
      if (b_vld_r) begin
        found_r <= last_r ? 1'b0 : found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    qual_r <= best_in.qual;
    last_r <= best_in.last;
    key_r  <= best_in.key;
    d2_r   <= best_in.sum;
    lim2_r <= lim2_nxt;
    if (b_vld_r) begin
      best_r <= best_nxt;
      bkey_r <= bkey_nxt;
    end
    if (b_vld_r && last_r) begin
      res_found_r <= found_nxt;
      res_key_r   <= found_nxt ? bkey_nxt : '0;
    end
  end

  always_comb begin
    res.vld   = res_vld_r;
    res.found = res_found_r;
    res.key   = res_key_r;
  end

endmodule

`default_nettype wire

// ----- design/nearest_point_within_radius_search.sv -----
// ----------------------------------------------------------------------------
// nearest_point_within_radius_search
// Table of point entries with write, remove by key and nearest query.
// Write: stored on acceptance. Remove: scans to a key match, one slot read per cycle.
// Query: starts once the output register is free; the RAM
// read port visits one slot per cycle, then a 3-cell distance chain and compare.
// Reset: synchronous; a clearing pass over every slot then runs, no request
// is taken until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_within_radius_search (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [nprs_pkg::CMD_W-1:0]          in_command,
  input  wire logic [nprs_pkg::SLOT_W-1:0]         in_slot,
  input  wire logic [nprs_pkg::KEY_W-1:0]          in_entity_key,
  input  wire logic signed [nprs_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [nprs_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [nprs_pkg::POS_W-1:0]   in_pos_z,
  input  wire logic [nprs_pkg::REACH_W-1:0]        in_reach,
  input  wire logic                                in_enabled,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic [nprs_pkg::KEY_W-1:0]               out_nearest_key
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_QWAIT  = 3'd2;
  localparam logic [2:0] ST_QRUN   = 3'd3;
  localparam logic [2:0] ST_QDRAIN = 3'd4;
  localparam logic [2:0] ST_RMRUN  = 3'd5;

  logic [2:0]                        state_r;
  logic [2:0]                        state_nxt;
  nprs_pkg::addr_t                   cnt_r;
  nprs_pkg::addr_t                   cnt_nxt;
  logic                              in_acc;
  nprs_pkg::slot_ext_t               slot_ext;
  logic                              slot_ok;
  nprs_pkg::entry_t                  wr_entry;
  nprs_pkg::entry_t                  rd_entry;
  nprs_pkg::entry_t                  rm_entry;
  logic [nprs_pkg::ENTRY_W-1:0]      rd_data;
  logic                              we;
  nprs_pkg::addr_t                   waddr;
  nprs_pkg::entry_t                  wdata;
  nprs_pkg::addr_t                   raddr;
  logic                              qrd_vld_nxt;
  logic                              qrd_vld_r;
  logic                              rmrd_vld_nxt;
  logic                              rmrd_vld_r;
  nprs_pkg::addr_t                   rd_addr_r;
  logic                              rd_last_r;
  logic                              q_load;
  logic [nprs_pkg::REACH_W-1:0]      q_reach_r;
  logic [nprs_pkg::KEY_W-1:0]        rm_key_r;
  logic                              rm_match;
  logic                              cnt_last;
  nprs_pkg::scan_t                   fr_nxt;
  nprs_pkg::scan_t                   fr_r;
  logic                              fr_vld_r;
  nprs_pkg::scan_t                   chain [4];
  logic signed [nprs_pkg::POS_W-1:0] q_in [3];
  nprs_pkg::res_t                    res;
  logic                              out_valid_r;
  logic                              out_found_r;
  logic [nprs_pkg::KEY_W-1:0]        out_key_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign slot_ext = nprs_pkg::slot_ext_t'(in_slot);
  assign slot_ok  = slot_ext < nprs_pkg::slot_ext_t'(nprs_pkg::TABLE_DEPTH);
  assign cnt_last = (cnt_r == nprs_pkg::LAST_ADDR);

  always_comb begin
    wr_entry.written = 1'b1;
    wr_entry.active  = 1'b1;
    wr_entry.enabled = in_enabled;
    wr_entry.key     = in_entity_key;
    wr_entry.x       = in_pos_x;
    wr_entry.y       = in_pos_y;
    wr_entry.z       = in_pos_z;
    wr_entry.reach   = in_reach;
  end

  assign rd_entry = rd_data;
  assign rm_match = rmrd_vld_r && rd_entry.written && (rd_entry.key == rm_key_r);

  always_comb begin
    rm_entry        = rd_entry;
    rm_entry.active = 1'b0;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    we           = 1'b0;
    waddr        = cnt_r;
    wdata        = '0;
    raddr        = cnt_r;
    qrd_vld_nxt  = 1'b0;
    rmrd_vld_nxt = 1'b0;
    q_load       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_command)
            nprs_pkg::CMD_WRITE: begin
              we    = slot_ok;
              waddr = slot_ext[nprs_pkg::ADDR_W-1:0];
              wdata = wr_entry;
            end
            nprs_pkg::CMD_REMOVE: begin
              cnt_nxt   = '0;
              state_nxt = ST_RMRUN;
            end
            nprs_pkg::CMD_QUERY: begin
              q_load    = 1'b1;
              state_nxt = ST_QWAIT;
            end
            default: ;
          endcase
        end
      end
      ST_QWAIT: begin
        if (!out_valid_r || out_ready) begin
          cnt_nxt   = '0;
          state_nxt = ST_QRUN;
        end
      end
      ST_QRUN: begin
        qrd_vld_nxt = 1'b1;
        cnt_nxt     = cnt_last ? '0 : cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_QDRAIN;
        end
      end
      ST_QDRAIN: begin
        if (res.vld) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RMRUN: begin
        rmrd_vld_nxt = 1'b1;
        cnt_nxt      = cnt_last ? '0 : cnt_r + 1'b1;
        if (rm_match) begin
          we        = 1'b1;
          waddr     = rd_addr_r;
          wdata     = rm_entry;
          state_nxt = ST_IDLE;
        end else if (rmrd_vld_r && rd_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      qrd_vld_r  <= 1'b0;
      rmrd_vld_r <= 1'b0;
      fr_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      qrd_vld_r  <= qrd_vld_nxt;
      rmrd_vld_r <= rmrd_vld_nxt;
      fr_vld_r   <= qrd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
    rd_last_r <= cnt_last;
    fr_r      <= fr_nxt;
    if (q_load) begin
      q_reach_r <= in_reach;
    end
    if (in_acc) begin
      rm_key_r <= in_entity_key;
    end
  end

  nprs_ram #(
    .WIDTH (nprs_pkg::ENTRY_W),
    .DEPTH (nprs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    fr_nxt.vld  = qrd_vld_r;
    fr_nxt.qual = rd_entry.active && rd_entry.enabled;
    fr_nxt.last = rd_last_r;
    fr_nxt.key  = rd_entry.key;
    fr_nxt.lim  = (rd_entry.reach < q_reach_r) ? rd_entry.reach : q_reach_r;
    fr_nxt.cx   = rd_entry.x;
    fr_nxt.cy   = rd_entry.y;
    fr_nxt.cz   = rd_entry.z;
    fr_nxt.sum  = '0;
  end

  always_comb begin
    chain[0]     = fr_r;
    chain[0].vld = fr_vld_r;
  end

  assign q_in[0] = in_pos_x;
  assign q_in[1] = in_pos_y;
  assign q_in[2] = in_pos_z;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    nprs_axis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q_load   (q_load),
      .q_pos    (q_in[k]),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  nprs_best u_best (
    .clk     (clk),
    .rst_n   (rst_n),
    .best_in (chain[3]),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_found_r <= res.found;
      out_key_r   <= res.key;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_nearest_key = out_key_r;

`ifndef SYNTHESIS
  a_res_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> !out_valid_r)
    else $error("result arrived while output register still full");

  a_res_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_QDRAIN)
    else $error("result produced outside a query drain");

  a_one_scan_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(qrd_vld_r && rmrd_vld_r))
    else $error("query and remove reads in flight together");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !chain[3].vld)
    else $error("distance chain busy while idle");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_nearest_point_within_radius_search.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_within_radius_search
// Self-checking bench for the nearest point search. A directed table covers
// the empty table, coordinate and reach extremes, disabled and removed
// entries, ties, the exact range boundary and an unknown command. Clustered
// random traffic follows. Query results are compared with literal outcomes
// or a shadow point table that is updated as requests are accepted.
// ----------------------------------------------------------------------------

module tb_nearest_point_within_radius_search;

  import nprs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam int HOLD_CYCLES    = 5000;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PLAN_ROWS      = 26;

  localparam logic signed [POS_W-1:0] P0      = 24'sd0;
  localparam logic signed [POS_W-1:0] PMX     = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] PMN     = 24'sh800000;
  localparam logic signed [POS_W-1:0] P256    = 24'sd256;
  localparam logic signed [POS_W-1:0] TIE_X   = 24'sh020000;
  localparam logic signed [POS_W-1:0] TIE_R   = 24'sh020200;
  localparam logic signed [POS_W-1:0] TIE_L   = 24'sh01FE00;
  localparam logic signed [POS_W-1:0] TIE_N   = 24'sh020064;
  localparam logic signed [POS_W-1:0] EDGE_X  = 24'sh040000;
  localparam logic signed [POS_W-1:0] EDGE_ON = 24'sh04012C;
  localparam logic signed [POS_W-1:0] EDGE_IN = 24'sh04012B;
  localparam logic signed [POS_W-1:0] ZK_X    = 24'sh060000;
  localparam logic [REACH_W-1:0]      RMX     = 23'h7FFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [SLOT_W-1:0]       slot;
    logic [KEY_W-1:0]        key;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [REACH_W-1:0]      reach;
    logic                    en;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
  } outcome_t;

  typedef enum logic {EXP_CALC, EXP_LIT} exp_src_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [SLOT_W-1:0]       slot;
    logic [KEY_W-1:0]        key;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [REACH_W-1:0]      reach;
    logic                    en;
    exp_src_t                src;
    logic                    found;
    logic [KEY_W-1:0]        nkey;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    '{CMD_QUERY,  10'd0,    16'h0000, P0, P0, P0, RMX, 1'b0, EXP_LIT, 1'b0, 16'h0000},
    '{CMD_WRITE,  10'd0,    16'h1234, P0, P0, P0, RMX, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd1023, 16'hFFFF, PMX, PMX, PMX, RMX, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd1,    16'h0001, PMN, PMN, PMN, 23'd0, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd2,    16'h00AA, P256, P0, P0, 23'd512, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, P0, P0, P0, RMX, 1'b0, EXP_LIT, 1'b1, 16'h1234},
    '{CMD_QUERY,  10'd0,    16'h0000, P0, P0, P0, 23'd0, 1'b0, EXP_LIT, 1'b0, 16'h0000},
    '{CMD_QUERY,  10'd0,    16'h0000, PMX, PMX, PMX, RMX, 1'b0, EXP_LIT, 1'b1, 16'hFFFF},
    '{CMD_QUERY,  10'd0,    16'h0000, PMN, PMN, PMN, RMX, 1'b0, EXP_LIT, 1'b0, 16'h0000},
    '{CMD_WRITE,  10'd5,    16'h0505, TIE_R, P0, P0, 23'd1024, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd6,    16'h0606, TIE_L, P0, P0, 23'd1024, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, TIE_X, P0, P0, 23'd2048, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd7,    16'h0707, EDGE_X, P0, P0, 23'd300, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, EDGE_ON, P0, P0, 23'd1000, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, EDGE_IN, P0, P0, 23'd1000, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_REMOVE, 10'd0,    16'h0505, P0, P0, P0, 23'd0, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, TIE_X, P0, P0, 23'd2048, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd9,    16'h0505, TIE_N, P0, P0, 23'd1024, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_REMOVE, 10'd0,    16'h0505, P0, P0, P0, 23'd0, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, TIE_X, P0, P0, 23'd2048, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_REMOVE, 10'd0,    16'hBEEF, P0, P0, P0, 23'd0, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_NONE,   10'h3FF,  16'hFFFF, PMX, PMX, PMX, RMX, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd10,   16'h0000, ZK_X, P0, P0, 23'd1000, 1'b1, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, ZK_X, P0, P0, 23'd10, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_WRITE,  10'd0,    16'h1234, P0, P0, P0, RMX, 1'b0, EXP_CALC, 1'b0, 16'h0},
    '{CMD_QUERY,  10'd0,    16'h0000, P0, P0, P0, RMX, 1'b0, EXP_CALC, 1'b0, 16'h0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_command;
  logic [SLOT_W-1:0]       in_slot;
  logic [KEY_W-1:0]        in_entity_key;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic signed [POS_W-1:0] in_pos_z;
  logic [REACH_W-1:0]      in_reach;
  logic                    in_enabled;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_found;
  logic [KEY_W-1:0]        out_nearest_key;

  // shadow point table
  logic                    tbl_written [TABLE_DEPTH];
  logic                    tbl_active  [TABLE_DEPTH];
  logic                    tbl_enabled [TABLE_DEPTH];
  logic [KEY_W-1:0]        tbl_key     [TABLE_DEPTH];
  logic signed [POS_W-1:0] tbl_x       [TABLE_DEPTH];
  logic signed [POS_W-1:0] tbl_y       [TABLE_DEPTH];
  logic signed [POS_W-1:0] tbl_z       [TABLE_DEPTH];
  logic [REACH_W-1:0]      tbl_reach   [TABLE_DEPTH];

  outcome_t    pending_results [$];
  outcome_t    next_due;
  int          fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int          snd_idle_pct = 38;
  int          rcv_idle_pct = 63;
  bit          hold_req     = 1'b0;

  nearest_point_within_radius_search uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_slot         (in_slot),
    .in_entity_key   (in_entity_key),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_reach        (in_reach),
    .in_enabled      (in_enabled),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_nearest_key (out_nearest_key)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] sq_span(logic signed [POS_W-1:0] a,
                                          logic signed [POS_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return 64'(d * d);
  endfunction

  function automatic outcome_t nearest_lookup(request_t q);
    outcome_t           res;
    logic [63:0]        best;
    logic [63:0]        d2;
    logic [63:0]        lim2;
    logic [REACH_W-1:0] lim;
    res  = '0;
    best = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_active[i] && tbl_enabled[i]) begin
        lim  = (tbl_reach[i] < q.reach) ? tbl_reach[i] : q.reach;
        lim2 = 64'(lim) * 64'(lim);
        d2   = sq_span(tbl_x[i], q.x) + sq_span(tbl_y[i], q.y) + sq_span(tbl_z[i], q.z);
        if (d2 < lim2 && (!res.found || d2 < best)) begin
          res.found = 1'b1;
          res.key   = tbl_key[i];
          best      = d2;
        end
      end
    end
    return res;
  endfunction

  function automatic void table_update(request_t r);
    bit hit;
    hit = 1'b0;
    if (r.cmd == CMD_WRITE) begin
      tbl_written[r.slot] = 1'b1;
      tbl_active[r.slot]  = 1'b1;
      tbl_enabled[r.slot] = r.en;
      tbl_key[r.slot]     = r.key;
      tbl_x[r.slot]       = r.x;
      tbl_y[r.slot]       = r.y;
      tbl_z[r.slot]       = r.z;
      tbl_reach[r.slot]   = r.reach;
    end else if (r.cmd == CMD_REMOVE) begin
      // first written slot with the key only, even if already inactive
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!hit && tbl_written[i] && tbl_key[i] == r.key) begin
          tbl_active[i] = 1'b0;
          hit = 1'b1;
        end
      end
    end
  endfunction

  function automatic logic signed [POS_W-1:0] blob_coord(int blob, bit coarse);
    int c;
    int off;
    case (blob)
      0: c = 0;
      1: c = 8384512;
      2: c = -8384512;
      default: c = 1193046;
    endcase
    off = int'($urandom_range(0, 4095)) - 2048;
    if (coarse) off = (off / 256) * 256;
    return POS_W'(c + off);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       kind;
    int       blob;
    int       pick;
    bit       coarse;
    kind   = $urandom_range(0, 99);
    blob   = $urandom_range(0, 3);
    coarse = ($urandom_range(0, 2) == 0);
    r.slot = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 63)) : SLOT_W'($urandom);
    r.key  = ($urandom_range(0, 3) != 0) ? KEY_W'($urandom_range(0, 31)) : KEY_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      r.x = POS_W'($urandom);
      r.y = POS_W'($urandom);
      r.z = POS_W'($urandom);
    end else begin
      r.x = blob_coord(blob, coarse);
      r.y = blob_coord(blob, coarse);
      r.z = blob_coord(blob, coarse);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.reach = '0;
    else if (pick < 6)
      r.reach = REACH_W'($urandom);
    else
      r.reach = REACH_W'($urandom_range(0, 6000));
    r.en = ($urandom_range(0, 6) != 0);
    if (kind < 45)
      r.cmd = CMD_WRITE;
    else if (kind < 62)
      r.cmd = CMD_REMOVE;
    else if (kind < 97)
      r.cmd = CMD_QUERY;
    else
      r.cmd = CMD_NONE;
    return r;
  endfunction

  task automatic submit_request(input request_t r, input bit typed, input outcome_t lit);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= r.cmd;
    in_slot       <= r.slot;
    in_entity_key <= r.key;
    in_pos_x      <= r.x;
    in_pos_y      <= r.y;
    in_pos_z      <= r.z;
    in_reach      <= r.reach;
    in_enabled    <= r.en;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (r.cmd == CMD_QUERY)
      pending_results.insert(pending_results.size(), typed ? lit : nearest_lookup(r));
    else
      table_update(r);
  endtask

  task automatic await_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    request_t r;
    int       sent;
    sent = 0;
    while (sent < count) begin
      r = random_request();
      submit_request(r, 1'b0, '0);
      if (r.cmd != CMD_NONE) sent++;
    end
  endtask

  // receiver: random back-pressure, or one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: found=%0b key=%h", out_found, out_nearest_key);
      end else begin
        next_due = pending_results.pop_front();
        if (out_found !== next_due.found || out_nearest_key !== next_due.key) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected found=%0b key=%h, got found=%0b key=%h",
                     next_due.found, next_due.key, out_found, out_nearest_key);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    request_t plan_req;
    outcome_t plan_out;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_WRITE;
    in_slot       <= '0;
    in_entity_key <= '0;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_pos_z      <= '0;
    in_reach      <= '0;
    in_enabled    <= 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_written[i] = 1'b0;
      tbl_active[i]  = 1'b0;
      tbl_enabled[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < PLAN_ROWS; n++) begin
      plan_req = '{plan[n].cmd, plan[n].slot, plan[n].key, plan[n].x, plan[n].y,
                   plan[n].z, plan[n].reach, plan[n].en};
      plan_out = '{plan[n].found, plan[n].nkey};
      submit_request(plan_req, plan[n].src == EXP_LIT, plan_out);
    end
    await_results();

    run_random(187);

    // swap idling and stall the output long enough to back up the input
    snd_idle_pct = 63;
    rcv_idle_pct = 38;
    hold_req     = 1'b1;
    run_random(187);
    await_results();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(186);
    await_results();

    // let a trailing remove finish before the verdict
    repeat (TABLE_DEPTH + 32) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/nprs_pkg.sv
design/nprs_ram.sv
design/nprs_axis_cell.sv
design/nprs_best.sv
design/nearest_point_within_radius_search.sv
verif/tb_nearest_point_within_radius_search.sv
